// File: hdl/hrlm_pkg.sv
// Shared types and constants for the HSV red-light pixel mask pipeline.
// Used by hrlm_div_stage and hsv_red_light_pixel_mask_top; no dependencies.
package hrlm_pkg;

	localparam int LVL_W   = 8;
	localparam int SIXTH_W = 11;
	localparam int NUM_W   = 17;
	localparam int DEN_W   = 9;
	localparam int QUO_W   = 8;
	localparam int HUE_WRAP = 180;

	typedef enum logic [2:0] {
		REG_RED_LOW_HUE_MAX  = 3'd0,
		REG_RED_HIGH_HUE_MIN = 3'd1,
		REG_RED_SAT_MIN      = 3'd2,
		REG_RED_VAL_MIN      = 3'd3,
		REG_BRIGHT_SAT_MAX   = 3'd4,
		REG_BRIGHT_VAL_MIN   = 3'd5,
		REG_DARK_VAL_MAX     = 3'd6,
		REG_ROI_LAST_ROW     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem_s;
		logic [NUM_W-1:0] rem_h;
		logic [DEN_W-1:0] den_s;
		logic [DEN_W-1:0] den_h;
		logic [QUO_W-1:0] quo_s;
		logic [QUO_W-1:0] quo_h;
		logic [LVL_W-1:0] val;
		logic             gray;
		logic             in_roi;
	} div_t;

endpackage

// File: hdl/hrlm_div_stage.sv
// One pipeline stage of the saturation and hue dividers: two restoring steps each.
// Depends on hrlm_pkg (div_t, widths).
module hrlm_div_stage #(
	parameter int TOP_BIT = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  hrlm_pkg::div_t in_data,
	output logic          out_valid,
	output hrlm_pkg::div_t out_data
);

	localparam int NW = hrlm_pkg::NUM_W;

	hrlm_pkg::div_t nxt;
	hrlm_pkg::div_t data_sn;
	logic           valid_sn;

	always_comb begin
		logic [NW-1:0] trial_s;
		logic [NW-1:0] trial_h;
		nxt = in_data;
		for (int i = 0; i < 2; i++) begin
			trial_s = NW'(in_data.den_s) << (TOP_BIT - i);
			trial_h = NW'(in_data.den_h) << (TOP_BIT - i);
			if (nxt.rem_s >= trial_s) begin
				nxt.rem_s = nxt.rem_s - trial_s;
				nxt.quo_s[TOP_BIT - i] = 1'b1;
			end
			if (nxt.rem_h >= trial_h) begin
				nxt.rem_h = nxt.rem_h - trial_h;
				nxt.quo_h[TOP_BIT - i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_sn <= nxt;
		end
	end

	assign out_valid = valid_sn;
	assign out_data  = data_sn;

endmodule

// File: hdl/hsv_red_light_pixel_mask_top.sv
// Top level of the HSV red-light pixel mask: BGR pixel in, mask bits out.
// Depends on hrlm_pkg and hrlm_div_stage.
//
// Channel | Direction | Payload
// s_axis  | in        | blue_level, green_level, red_level, pixel_row
// m_axis  | out       | light_mask, red_hit, dark_hit
// cfg     | in        | one register write per cycle, no read-back
//
// The pipeline has 8 register stages; one pixel per cycle is sustained while m_axis_tready is high.
// The saturation and hue divisions take four stages, two quotient bits per stage.
// Each stage holds its own valid bit and loads when it is empty or its successor can move,
// so bubbles close up and input keeps flowing while a result waits, until every stage is full.
// Reset clears the valid bits and loads the threshold registers with defaults.
module hsv_red_light_pixel_mask_top #(
	parameter int ROW_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// blue_level[7:0], green_level[15:8], red_level[23:16], pixel_row, zero pad
	input  logic [((24 + ROW_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// light_mask[0], red_hit[1], dark_hit[2], zero pad
	output logic [7:0]          m_axis_tdata,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [ROW_BITS-1:0] cfg_data
);

	localparam int LW = hrlm_pkg::LVL_W;
	localparam int XW = hrlm_pkg::SIXTH_W;
	localparam int NW = hrlm_pkg::NUM_W;
	localparam int QW = hrlm_pkg::QUO_W;

	logic [LW-1:0]       red_low_hue_max_q;
	logic [LW-1:0]       red_high_hue_min_q;
	logic [LW-1:0]       red_sat_min_q;
	logic [LW-1:0]       red_val_min_q;
	logic [LW-1:0]       bright_sat_max_q;
	logic [LW-1:0]       bright_val_min_q;
	logic [LW-1:0]       dark_val_max_q;
	logic [ROW_BITS-1:0] roi_last_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_low_hue_max_q  <= LW'(26);
			red_high_hue_min_q <= LW'(150);
			red_sat_min_q      <= LW'(25);
			red_val_min_q      <= LW'(210);
			bright_sat_max_q   <= LW'(30);
			bright_val_min_q   <= LW'(255);
			dark_val_max_q     <= LW'(135);
			roi_last_row_q     <= ROW_BITS'(568);
		end else if (cfg_wr_en) begin
			case (hrlm_pkg::cfg_reg_t'(cfg_index))
				hrlm_pkg::REG_RED_LOW_HUE_MAX:  red_low_hue_max_q  <= cfg_data[LW-1:0];
				hrlm_pkg::REG_RED_HIGH_HUE_MIN: red_high_hue_min_q <= cfg_data[LW-1:0];
				hrlm_pkg::REG_RED_SAT_MIN:      red_sat_min_q      <= cfg_data[LW-1:0];
				hrlm_pkg::REG_RED_VAL_MIN:      red_val_min_q      <= cfg_data[LW-1:0];
				hrlm_pkg::REG_BRIGHT_SAT_MAX:   bright_sat_max_q   <= cfg_data[LW-1:0];
				hrlm_pkg::REG_BRIGHT_VAL_MIN:   bright_val_min_q   <= cfg_data[LW-1:0];
				hrlm_pkg::REG_DARK_VAL_MAX:     dark_val_max_q     <= cfg_data[LW-1:0];
				hrlm_pkg::REG_ROI_LAST_ROW:     roi_last_row_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// flow control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;

	assign adv8 = !valid_s8 || m_axis_tready;
	assign adv7 = !valid_s7 || adv8;
	assign adv6 = !valid_s6 || adv7;
	assign adv5 = !valid_s5 || adv6;
	assign adv4 = !valid_s4 || adv5;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign s_axis_tready = adv1;

	// stage 1: channel extremes, row test
	logic [LW-1:0] in_b, in_g, in_r;
	logic [ROW_BITS-1:0] in_row;
	logic [LW-1:0] hi_c, lo_c;
	logic          rmax_c, gmax_c;

	assign in_b   = s_axis_tdata[7:0];
	assign in_g   = s_axis_tdata[15:8];
	assign in_r   = s_axis_tdata[23:16];
	assign in_row = s_axis_tdata[24 +: ROW_BITS];

	always_comb begin
		hi_c = in_b;
		lo_c = in_b;
		if (in_g > hi_c) hi_c = in_g;
		if (in_r > hi_c) hi_c = in_r;
		if (in_g < lo_c) lo_c = in_g;
		if (in_r < lo_c) lo_c = in_r;
		rmax_c = (in_r == hi_c);
		gmax_c = !rmax_c && (in_g == hi_c);
	end

	logic [LW-1:0] b_s1, g_s1, r_s1, hi_s1, lo_s1;
	logic          rmax_s1, gmax_s1, inside_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			b_s1      <= in_b;
			g_s1      <= in_g;
			r_s1      <= in_r;
			hi_s1     <= hi_c;
			lo_s1     <= lo_c;
			rmax_s1   <= rmax_c;
			gmax_s1   <= gmax_c;
			inside_s1 <= (in_row <= roi_last_row_q);
		end
	end

	// stage 2: span and raw hue sector
	logic [LW-1:0] span_c;
	logic [XW-1:0] sixth_c;

	always_comb begin
		span_c = hi_s1 - lo_s1;
		if (rmax_s1) begin
			if (g_s1 >= b_s1) begin
				sixth_c = XW'(g_s1 - b_s1);
			end else begin
				sixth_c = XW'(6) * XW'(span_c) - XW'(b_s1 - g_s1);
			end
		end else if (gmax_s1) begin
			sixth_c = XW'(b_s1) + (XW'(span_c) << 1) - XW'(r_s1);
		end else begin
			sixth_c = XW'(r_s1) + (XW'(span_c) << 2) - XW'(g_s1);
		end
	end

	logic [LW-1:0] hi_s2, span_s2;
	logic [XW-1:0] sixth_s2;
	logic          inside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			hi_s2     <= hi_s1;
			span_s2   <= span_c;
			sixth_s2  <= sixth_c;
			inside_s2 <= inside_s1;
		end
	end

	// stage 3: dividends and divisors
	hrlm_pkg::div_t div_c, div_s3, div_s4, div_s5, div_s6, div_s7;

	always_comb begin
		div_c.rem_s  = (NW'(span_s2) << 9) - (NW'(span_s2) << 1) + NW'(hi_s2);
		div_c.rem_h  = (NW'(sixth_s2) << 6) - (NW'(sixth_s2) << 2) + NW'(span_s2);
		div_c.den_s  = {hi_s2, 1'b0};
		div_c.den_h  = {span_s2, 1'b0};
		div_c.quo_s  = '0;
		div_c.quo_h  = '0;
		div_c.val    = hi_s2;
		div_c.gray   = (span_s2 == '0);
		div_c.in_roi = inside_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			div_s3 <= div_c;
		end
	end

	// stages 4 to 7: quotient bits 7..0
	hrlm_div_stage #(.TOP_BIT(7)) u_div4 (
		.clk(clk), .arst_n(arst_n), .en(adv4), .in_valid(valid_s3), .in_data(div_s3),
		.out_valid(valid_s4), .out_data(div_s4)
	);
	hrlm_div_stage #(.TOP_BIT(5)) u_div5 (
		.clk(clk), .arst_n(arst_n), .en(adv5), .in_valid(valid_s4), .in_data(div_s4),
		.out_valid(valid_s5), .out_data(div_s5)
	);
	hrlm_div_stage #(.TOP_BIT(3)) u_div6 (
		.clk(clk), .arst_n(arst_n), .en(adv6), .in_valid(valid_s5), .in_data(div_s5),
		.out_valid(valid_s6), .out_data(div_s6)
	);
	hrlm_div_stage #(.TOP_BIT(1)) u_div7 (
		.clk(clk), .arst_n(arst_n), .en(adv7), .in_valid(valid_s6), .in_data(div_s6),
		.out_valid(valid_s7), .out_data(div_s7)
	);

	// stage 8: hue wrap, thresholds, output register
	logic [QW-1:0] hue_c, sat_c;
	logic          red_c, bright_c, dark_c, mask_c;

	always_comb begin
		if (div_s7.gray) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			sat_c = div_s7.quo_s;
			if (div_s7.quo_h >= QW'(hrlm_pkg::HUE_WRAP)) begin
				hue_c = div_s7.quo_h - QW'(hrlm_pkg::HUE_WRAP);
			end else begin
				hue_c = div_s7.quo_h;
			end
		end
		red_c = (sat_c >= red_sat_min_q) && (div_s7.val >= red_val_min_q) &&
			((hue_c <= red_low_hue_max_q) || (hue_c >= red_high_hue_min_q));
		bright_c = (sat_c <= bright_sat_max_q) && (div_s7.val >= bright_val_min_q);
		dark_c   = (div_s7.val <= dark_val_max_q);
		mask_c   = (red_c || bright_c) && div_s7.in_roi;
	end

	logic [2:0] res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (adv8) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv8) begin
			res_s8 <= {dark_c, red_c, mask_c};
		end
	end

	assign m_axis_tvalid = valid_s8;
	assign m_axis_tdata  = {5'b00000, res_s8};

endmodule

// File: bench/hsv_red_light_pixel_mask_top_tb.sv
// Self-checking bench for hsv_red_light_pixel_mask_top: streams BGR pixels with rows,
// predicts the three mask bits per pixel and compares them in order. Depends on hrlm_pkg.
`timescale 1ns / 1ps

module hsv_red_light_pixel_mask_top_tb;

	localparam int ROW_BITS = 12;
	localparam int TDATA_W  = ((24 + ROW_BITS + 7) / 8) * 8;
	localparam int NUM_REGS = 8;

	typedef struct packed {
		logic light_mask;
		logic red_hit;
		logic dark_hit;
	} mask_bits_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [7:0]          m_axis_tdata;
	logic                cfg_wr_en = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [ROW_BITS-1:0] cfg_data = '0;

	logic [ROW_BITS-1:0] thr [NUM_REGS];
	logic [ROW_BITS-1:0] thr_next [NUM_REGS];
	mask_bits_t          expected_masks[$];
	int                  mismatch_count = 0;
	int                  stall_left = 0;
	bit                  no_gaps = 1'b0;

	hsv_red_light_pixel_mask_top #(
		.ROW_BITS(ROW_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic mask_bits_t predict_mask(input logic [7:0] b, g, r,
			input logic [ROW_BITS-1:0] row);
		int hi, lo, span, sat, hue, raw;
		logic red, bright;
		mask_bits_t res;
		hi = b;
		lo = b;
		if (g > hi) hi = g;
		if (r > hi) hi = r;
		if (g < lo) lo = g;
		if (r < lo) lo = r;
		span = hi - lo;
		if (span == 0) begin
			hue = 0;
			sat = 0;
		end else begin
			sat = (510 * span + hi) / (2 * hi);
			if (hi == r)
				raw = int'(g) - int'(b);
			else if (hi == g)
				raw = int'(b) - int'(r) + 2 * span;
			else
				raw = int'(r) - int'(g) + 4 * span;
			if (raw < 0)
				raw += 6 * span;
			hue = (raw * 60 + span) / (2 * span);
			if (hue >= hrlm_pkg::HUE_WRAP)
				hue -= hrlm_pkg::HUE_WRAP;
		end
		red = (sat >= thr[hrlm_pkg::REG_RED_SAT_MIN][7:0]) &&
			(hi >= thr[hrlm_pkg::REG_RED_VAL_MIN][7:0]) &&
			((hue <= thr[hrlm_pkg::REG_RED_LOW_HUE_MAX][7:0]) ||
			(hue >= thr[hrlm_pkg::REG_RED_HIGH_HUE_MIN][7:0]));
		bright = (sat <= thr[hrlm_pkg::REG_BRIGHT_SAT_MAX][7:0]) &&
			(hi >= thr[hrlm_pkg::REG_BRIGHT_VAL_MIN][7:0]);
		res.red_hit = red;
		res.light_mask = (red || bright) && (row <= thr[hrlm_pkg::REG_ROI_LAST_ROW]);
		res.dark_hit = hi <= thr[hrlm_pkg::REG_DARK_VAL_MAX][7:0];
		return res;
	endfunction

	function automatic int gap_len();
		int pick;
		if (no_gaps)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin : result_check
		mask_bits_t got, want;
		int n;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.light_mask = m_axis_tdata[0];
				got.red_hit = m_axis_tdata[1];
				got.dark_hit = m_axis_tdata[2];
				if (expected_masks.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result mask=%b red=%b dark=%b", $realtime,
							got.light_mask, got.red_hit, got.dark_hit);
				end else begin
					want = expected_masks.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp mask=%b red=%b dark=%b got mask=%b red=%b dark=%b",
								$realtime, want.light_mask, want.red_hit, want.dark_hit,
								got.light_mask, got.red_hit, got.dark_hit);
					end
				end
			end
			n = gap_len();
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (n > 0) begin
				m_axis_tready <= 1'b0;
				stall_left = n - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_pixel(input logic [7:0] b, g, r, input logic [ROW_BITS-1:0] row);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(TDATA_W - 24 - ROW_BITS){1'b0}}, row, r, g, b};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_masks.insert(expected_masks.size(), predict_mask(b, g, r, row));
	endtask

	// hold valid low and wait until every result is back
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (expected_masks.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_thresholds();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= hrlm_pkg::cfg_reg_t'(i);
			cfg_data <= thr_next[i];
			@(posedge clk);
			thr[i] = thr_next[i];
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_defaults();
		thr_next[hrlm_pkg::REG_RED_LOW_HUE_MAX] = 26;
		thr_next[hrlm_pkg::REG_RED_HIGH_HUE_MIN] = 150;
		thr_next[hrlm_pkg::REG_RED_SAT_MIN] = 25;
		thr_next[hrlm_pkg::REG_RED_VAL_MIN] = 210;
		thr_next[hrlm_pkg::REG_BRIGHT_SAT_MAX] = 30;
		thr_next[hrlm_pkg::REG_BRIGHT_VAL_MIN] = 255;
		thr_next[hrlm_pkg::REG_DARK_VAL_MAX] = 135;
		thr_next[hrlm_pkg::REG_ROI_LAST_ROW] = 568;
	endtask

	task automatic send_random_pixel();
		int kind, base, roi;
		logic [7:0] b, g, r, t;
		logic [ROW_BITS-1:0] row;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			b = 8'($urandom);
			g = 8'($urandom);
			r = 8'($urandom);
		end else if (kind < 65) begin
			r = 8'($urandom_range(180, 255));
			g = 8'($urandom_range(0, 80));
			b = 8'($urandom_range(0, 80));
			if ($urandom_range(0, 1)) begin
				t = g;
				g = b;
				b = t;
			end
		end else if (kind < 80) begin
			base = $urandom_range(200, 255);
			r = 8'(base - int'($urandom_range(0, 20)));
			g = 8'(base - int'($urandom_range(0, 20)));
			b = 8'(base - int'($urandom_range(0, 20)));
			if ($urandom_range(0, 1))
				r = 8'(base);
		end else if (kind < 90) begin
			r = 8'($urandom);
			g = r;
			b = r;
		end else begin
			r = 8'($urandom_range(0, 140));
			g = 8'($urandom_range(0, 140));
			b = 8'($urandom_range(0, 140));
		end
		roi = thr[hrlm_pkg::REG_ROI_LAST_ROW];
		if ($urandom_range(0, 1))
			row = ROW_BITS'($urandom);
		else
			row = ROW_BITS'(roi + int'($urandom_range(0, 16)) - 8);
		send_pixel(b, g, r, row);
	endtask

	task automatic test_directed_pixels();
		send_pixel(8'd0, 8'd0, 8'd0, 12'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 12'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 12'd568);
		send_pixel(8'd255, 8'd255, 8'd255, 12'd569);
		send_pixel(8'd255, 8'd255, 8'd255, 12'd4095);
		send_pixel(8'd135, 8'd135, 8'd135, 12'd10);
		send_pixel(8'd136, 8'd136, 8'd136, 12'd10);
		send_pixel(8'd0, 8'd0, 8'd255, 12'd100);
		send_pixel(8'd0, 8'd255, 8'd0, 12'd100);
		send_pixel(8'd255, 8'd0, 8'd0, 12'd100);
		send_pixel(8'd0, 8'd255, 8'd255, 12'd100);
		send_pixel(8'd255, 8'd255, 8'd0, 12'd100);
		send_pixel(8'd255, 8'd0, 8'd255, 12'd100);
		send_pixel(8'd1, 8'd0, 8'd255, 12'd100);
		send_pixel(8'd0, 8'd221, 8'd255, 12'd100);
		send_pixel(8'd0, 8'd226, 8'd255, 12'd100);
		send_pixel(8'd250, 8'd255, 8'd255, 12'd100);
		send_pixel(8'd0, 8'd0, 8'd209, 12'd100);
		send_pixel(8'd0, 8'd0, 8'd210, 12'd100);
		send_pixel(8'd200, 8'd200, 8'd255, 12'd100);
		send_pixel(8'd255, 8'd0, 8'd254, 12'd2048);
		send_pixel(8'd170, 8'd85, 8'd240, 12'd1365);
		drain_pipeline();
	endtask

	task automatic test_threshold_extremes();
		for (int i = 0; i < NUM_REGS; i++)
			thr_next[i] = '0;
		apply_thresholds();
		repeat (60) send_random_pixel();
		drain_pipeline();
		for (int i = 0; i < NUM_REGS; i++)
			thr_next[i] = '1;
		apply_thresholds();
		repeat (60) send_random_pixel();
		drain_pipeline();
		load_defaults();
		apply_thresholds();
		repeat (60) send_random_pixel();
		drain_pipeline();
	endtask

	task automatic test_random_thresholds();
		for (int phase = 0; phase < 10; phase++) begin
			for (int i = 0; i < NUM_REGS; i++)
				thr_next[i] = ROW_BITS'($urandom);
			thr_next[hrlm_pkg::REG_RED_LOW_HUE_MAX][7:0] = 8'($urandom_range(0, 180));
			thr_next[hrlm_pkg::REG_RED_HIGH_HUE_MIN][7:0] = 8'($urandom_range(0, 180));
			if (phase % 3 == 0) begin
				thr_next[hrlm_pkg::REG_RED_SAT_MIN][7:0] = 8'($urandom_range(0, 60));
				thr_next[hrlm_pkg::REG_RED_VAL_MIN][7:0] = 8'($urandom_range(150, 255));
				thr_next[hrlm_pkg::REG_BRIGHT_SAT_MAX][7:0] = 8'($urandom_range(0, 60));
				thr_next[hrlm_pkg::REG_BRIGHT_VAL_MIN][7:0] = 8'($urandom_range(200, 255));
			end
			apply_thresholds();
			repeat (90) send_random_pixel();
			drain_pipeline();
		end
	endtask

	task automatic test_back_to_back();
		load_defaults();
		apply_thresholds();
		no_gaps = 1'b1;
		repeat (150) send_random_pixel();
		drain_pipeline();
		no_gaps = 1'b0;
	endtask

	initial begin
		load_defaults();
		for (int i = 0; i < NUM_REGS; i++)
			thr[i] = thr_next[i];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_pixels();
		test_threshold_extremes();
		test_random_thresholds();
		test_back_to_back();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_masks.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
